### rtl/tpnf_pkg.sv
// Shared constants, types and helper functions of the neighbor fill core.
`timescale 1ns / 1ps
package tpnf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  // history must span two rows plus the window corners plus what is in flight
  localparam int MEM_AW      = $clog2(2 * MAX_WIDTH + 4 + QUEUE_DEPTH + 4);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
  localparam int DIFF_W      = $clog2(MAX_WIDTH + 3);
  localparam int ROW_W       = 16;
  localparam int SUM_W       = 11;
  localparam int CNT_W       = 4;

  localparam logic [2:0] REG_RED_SHIFT    = 3'd0;
  localparam logic [2:0] REG_GREEN_SHIFT  = 3'd1;
  localparam logic [2:0] REG_BLUE_SHIFT   = 3'd2;
  localparam logic [2:0] REG_ALPHA_SHIFT  = 3'd3;
  localparam logic [2:0] REG_TRANS_MODE   = 3'd4;
  localparam logic [2:0] REG_BITFIELDS    = 3'd5;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd6;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd7;

  localparam logic [1:0] TMODE_KEEP  = 2'd0;
  localparam logic [1:0] TMODE_BLACK = 2'd1;
  localparam logic [1:0] TMODE_AVG   = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
    logic [4:0]  alpha_shift;
    logic [1:0]  transparency_mode;
    logic        bitfields_mode;
    logic [11:0] image_width;
    logic [15:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [MEM_AW-1:0] addr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              eor;
    logic              eof;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [31:0]       data;
  } mem_wr_t;

  function automatic logic [WEFF_W-1:0] width_eff(input logic [11:0] w);
    if (w == 12'd0) return WEFF_W'(1);
    else if (32'(w) > 32'(MAX_WIDTH)) return WEFF_W'(MAX_WIDTH);
    else return WEFF_W'(w);
  endfunction

  function automatic logic [ROW_W-1:0] height_eff(input logic [15:0] h);
    return (h == 16'd0) ? ROW_W'(1) : h;
  endfunction

endpackage

### rtl/tpnf_queue.sv
// Small job queue between the front and the back of the neighbor fill core.
`timescale 1ns / 1ps
module tpnf_queue import tpnf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t pop_job
);

  job_t               slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign avail   = (count_r != '0);
  assign pop_job = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/tpnf_front.sv
// Front end: accept beats, store pixels, track positions and issue output jobs.
`timescale 1ns / 1ps
module tpnf_front import tpnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        restart,
  input  logic        in_acc,
  input  logic        in_cmd,
  input  logic [31:0] in_pixel,
  output mem_wr_t     mem_wr,
  output logic        job_push,
  output job_t        job
);

  logic [WEFF_W-1:0] w;
  logic [ROW_W-1:0]  h;

  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic              in_done_r, in_done_nxt;
  logic [MEM_AW-1:0] in_addr_r, in_addr_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [MEM_AW-1:0] out_addr_r, out_addr_nxt;
  logic [DIFF_W-1:0] diff_r, diff_nxt, diff_inc;

  logic store, release_job, in_last_col, out_last_col, out_last_row;

  assign w = width_eff(cfg.image_width);
  assign h = height_eff(cfg.image_height);

  always_comb begin
    store        = in_acc && (in_cmd == CMD_PIXEL) && !in_done_r;
    in_last_col  = (WEFF_W'(in_col_r) + 1'b1) == w;
    out_last_col = (WEFF_W'(out_col_r) + 1'b1) == w;
    out_last_row = (out_row_r == h - 1'b1);

    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_done_nxt  = in_done_r;
    in_addr_nxt  = in_addr_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_addr_nxt = out_addr_r;
    diff_inc     = diff_r + DIFF_W'(store);

    if (store) begin
      in_addr_nxt = in_addr_r + 1'b1;
      if (in_last_col) begin
        in_col_nxt = '0;
        if (in_row_r == h - 1'b1) begin
          in_done_nxt = 1'b1;
        end else begin
          in_row_nxt = in_row_r + 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end

    // release once the lower-right neighbor is in, or when the frame is complete
    release_job = in_acc && (diff_inc != '0) &&
                  (in_done_nxt || (diff_inc >= DIFF_W'(w) + DIFF_W'(2)));

    diff_nxt = diff_inc;
    if (release_job) begin
      out_addr_nxt = out_addr_r + 1'b1;
      diff_nxt     = diff_inc - 1'b1;
      if (out_last_col && out_last_row) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        in_done_nxt = 1'b0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        diff_nxt    = '0;
      end else if (out_last_col) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end

    // geometry change drops the frame in progress; the new frame starts at the
    // next free history slot
    if (restart) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_done_nxt  = 1'b0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_addr_nxt = in_addr_nxt;
      diff_nxt     = '0;
    end
  end

  assign mem_wr.en   = store;
  assign mem_wr.addr = in_addr_r;
  assign mem_wr.data = in_pixel;

  assign job_push = release_job;
  assign job.addr = out_addr_r;
  assign job.col  = out_col_r;
  assign job.row  = out_row_r;
  assign job.eor  = out_last_col;
  assign job.eof  = out_last_col && out_last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_done_r  <= 1'b0;
      in_addr_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_addr_r <= '0;
      diff_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_done_r  <= in_done_nxt;
      in_addr_r  <= in_addr_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_addr_r <= out_addr_nxt;
      diff_r     <= diff_nxt;
    end
  end

endmodule

### rtl/tpnf_back.sv
// Back end: pixel history memory, 3x3 window walk, averaging and output register.
`timescale 1ns / 1ps
module tpnf_back import tpnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  mem_wr_t     mem_wr,
  input  logic        job_avail,
  input  job_t        job_in,
  output logic        job_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam int STEP_W = $clog2(SUM_W + 1);

  function automatic logic [7:0] field_of(input logic [31:0] p, input logic [4:0] s);
    logic [31:0] sh;
    sh = p >> s;
    return sh[7:0];
  endfunction

  logic [31:0] mem [2**MEM_AW];

  logic [2:0]        state_r, state_nxt;
  job_t              job_r;
  logic [3:0]        slot_r;
  logic [3:0]        slot_d_r;
  logic              rd_vld_r, in_bounds_d_r;
  logic [31:0]       rd_data_r;
  logic [31:0]       center_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r_r, sum_g_r, sum_b_r;
  logic [SUM_W-1:0]  num_r_r, num_g_r, num_b_r;
  logic [CNT_W-1:0]  rem_r_r, rem_g_r, rem_b_r;
  logic [STEP_W-1:0] step_r;

  logic [WEFF_W-1:0] w;
  logic [ROW_W-1:0]  h;
  logic              dxm, dxp, dym, dyp, rd_en, in_bounds;
  logic [MEM_AW-1:0] rd_addr;
  logic [31:0]       pix_nxt;
  logic              out_free;

  assign w = width_eff(cfg.image_width);
  assign h = height_eff(cfg.image_height);

  // neighbor address and bounds for the slot being issued
  always_comb begin
    dym = (slot_r < 4'd3);
    dyp = (slot_r >= 4'd6);
    dxm = slot_r inside {4'd0, 4'd3, 4'd6};
    dxp = slot_r inside {4'd2, 4'd5, 4'd8};
    rd_addr = job_r.addr;
    if (dym) rd_addr = rd_addr - MEM_AW'(w);
    if (dyp) rd_addr = rd_addr + MEM_AW'(w);
    if (dxm) rd_addr = rd_addr - 1'b1;
    if (dxp) rd_addr = rd_addr + 1'b1;
    in_bounds = !(dxm && job_r.col == '0) &&
                !(dxp && (WEFF_W'(job_r.col) + 1'b1) >= w) &&
                !(dym && job_r.row == '0) &&
                !(dyp && (job_r.row + 1'b1) >= h);
    rd_en = (state_r == S_READ);
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  function automatic logic [SUM_W+CNT_W-1:0] div_step(input logic [SUM_W-1:0] num,
                                                      input logic [CNT_W-1:0] rem,
                                                      input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    logic           qb;
    t  = {rem, num[SUM_W-1]};
    qb = (t >= {1'b0, d});
    if (qb) t = t - {1'b0, d};
    return {num[SUM_W-2:0], qb, t[CNT_W-1:0]};
  endfunction

  // final pixel from the center word and the quotients
  always_comb begin
    logic [7:0] r, g, b, a;
    r = field_of(center_r, cfg.red_shift);
    g = field_of(center_r, cfg.green_shift);
    b = field_of(center_r, cfg.blue_shift);
    a = field_of(center_r, cfg.alpha_shift);
    if (a == 8'd0 && cfg.transparency_mode == TMODE_BLACK) begin
      r = 8'd0; g = 8'd0; b = 8'd0;
    end else if (a == 8'd0 && cfg.transparency_mode == TMODE_AVG) begin
      if (cnt_r == '0) begin
        r = 8'd0; g = 8'd0; b = 8'd0;
      end else begin
        r = num_r_r[7:0]; g = num_g_r[7:0]; b = num_b_r[7:0];
      end
    end
    pix_nxt = cfg.bitfields_mode ? {a, b, g, r} : center_r;
  end

  assign out_free = !out_tvalid || out_tready;
  assign job_pop  = (state_r == S_IDLE) && job_avail;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (job_avail) state_nxt = S_READ;
      S_READ: if (slot_r == 4'd8) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (step_r == STEP_W'(SUM_W - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (state_r == S_OUT && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_d_r      <= slot_r;
    in_bounds_d_r <= in_bounds;
    if (job_pop) begin
      job_r   <= job_in;
      slot_r  <= '0;
      cnt_r   <= '0;
      sum_r_r <= '0;
      sum_g_r <= '0;
      sum_b_r <= '0;
    end
    if (rd_en) begin
      slot_r <= slot_r + 1'b1;
    end
    // accumulate the word read on the previous cycle
    if (rd_vld_r) begin
      if (slot_d_r == 4'd4) begin
        center_r <= rd_data_r;
      end else if (in_bounds_d_r && field_of(rd_data_r, cfg.alpha_shift) != 8'd0) begin
        cnt_r   <= cnt_r + 1'b1;
        sum_r_r <= sum_r_r + SUM_W'(field_of(rd_data_r, cfg.red_shift));
        sum_g_r <= sum_g_r + SUM_W'(field_of(rd_data_r, cfg.green_shift));
        sum_b_r <= sum_b_r + SUM_W'(field_of(rd_data_r, cfg.blue_shift));
      end
    end
    if (state_r == S_PREP) begin
      num_r_r <= sum_r_r;
      num_g_r <= sum_g_r;
      num_b_r <= sum_b_r;
      rem_r_r <= '0;
      rem_g_r <= '0;
      rem_b_r <= '0;
      step_r  <= '0;
    end
    if (state_r == S_DIV) begin
      {num_r_r, rem_r_r} <= div_step(num_r_r, rem_r_r, cnt_r);
      {num_g_r, rem_g_r} <= div_step(num_g_r, rem_g_r, cnt_r);
      {num_b_r, rem_b_r} <= div_step(num_b_r, rem_b_r, cnt_r);
      step_r <= step_r + 1'b1;
    end
    if (state_r == S_OUT && out_free) begin
      out_tdata <= pix_nxt;
      out_tlast <= job_r.eof;
      out_tuser <= job_r.eor;
    end
  end

endmodule

### rtl/transparent_pixel_neighbor_fill_core.sv
// Top level of the transparent pixel neighbor fill core.
`timescale 1ns / 1ps
// Pixels of one frame enter in raster order as beats with in_tuser low; after
// the last pixel, send image_width+1 flush beats (in_tuser high) to drain the
// frame. Each output pixel trails its input by image_width+1 beats, since its
// lower-right neighbor must have arrived. In bitfields mode the R, G, B and A
// bytes are taken at the configured shifts and repacked R at bit 0 up to A at
// bit 24; alpha-zero pixels can be cleared to black or filled with the
// truncated average of their opaque 3x3 neighbors. The front accepts one beat
// per cycle until its four-entry job queue is full; the back works one output
// pixel at a time and takes no new job until that pixel is in the output
// register: it takes the job, makes nine reads through the single read port of
// the history memory, settles the sums in its WAIT and PREP states, runs three
// 11-step restoring dividers side by side, one per channel, and loads the output
// register. No clearing pass is needed after reset. The user must write
// configuration registers only while the core is idle; the core does not enforce it.
module transparent_pixel_neighbor_fill_core import tpnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_in
  input  logic        in_tuser,   // [0] command: 0 pixel, 1 flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pixel_out
  output logic        out_tlast,  // end_of_frame
  output logic        out_tuser,  // [0] end_of_row
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  mem_wr_t mem_wr;
  job_t    push_job, pop_job;
  logic    cfg_acc, restart, in_acc, q_full, q_avail, job_push, job_pop;

  // register writes always complete in one beat
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_shift         <= 5'd16;
      cfg_r.green_shift       <= 5'd8;
      cfg_r.blue_shift        <= 5'd0;
      cfg_r.alpha_shift       <= 5'd24;
      cfg_r.transparency_mode <= TMODE_KEEP;
      cfg_r.bitfields_mode    <= 1'b1;
      cfg_r.image_width       <= 12'd2048;
      cfg_r.image_height      <= 16'd1;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_RED_SHIFT:    cfg_r.red_shift         <= cfg_data[4:0];
        REG_GREEN_SHIFT:  cfg_r.green_shift       <= cfg_data[4:0];
        REG_BLUE_SHIFT:   cfg_r.blue_shift        <= cfg_data[4:0];
        REG_ALPHA_SHIFT:  cfg_r.alpha_shift       <= cfg_data[4:0];
        REG_TRANS_MODE:   cfg_r.transparency_mode <= cfg_data[1:0];
        REG_BITFIELDS:    cfg_r.bitfields_mode    <= cfg_data[0];
        REG_IMAGE_WIDTH:  cfg_r.image_width       <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height      <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold input beats while the job queue is full
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  tpnf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_acc   (in_acc),
    .in_cmd   (in_tuser),
    .in_pixel (in_tdata),
    .mem_wr   (mem_wr),
    .job_push (job_push),
    .job      (push_job)
  );

  tpnf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (job_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  tpnf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .mem_wr     (mem_wr),
    .job_avail  (q_avail),
    .job_in     (pop_job),
    .job_pop    (job_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/tpnf_checker.sv
// Port-level checker of the neighbor fill core and its bind.
`timescale 1ns / 1ps
module tpnf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic out_tuser
);

  // a stalled output beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // the last pixel of a frame is also the last pixel of its row
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of frame without end of row");

  // leaving reset: nothing offered, input open
  a_reset_state: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // just out of reset, the output cannot already carry a result
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n, 2) && rst_n |-> !out_tvalid)
    else $error("result without a source beat");

endmodule

bind transparent_pixel_neighbor_fill_core tpnf_checker u_tpnf_checker (.*);

### tb/transparent_pixel_neighbor_fill_core_test.sv
// Self-checking testbench for the transparent pixel neighbor fill core.
`timescale 1ns / 1ps
module transparent_pixel_neighbor_fill_core_test;
  import tpnf_pkg::*;

  localparam int HIST_DEPTH  = 2 * MAX_WIDTH + 4;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 100;

  typedef struct {
    logic [31:0] pixel;
    logic        eor;
    logic        eof;
  } out_pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  transparent_pixel_neighbor_fill_core dut (.*);

  always #1 clk = ~clk;

  // Shadow of the configuration and the frame state.
  logic [4:0]  sh_red, sh_green, sh_blue, sh_alpha;
  logic [1:0]  fill_mode;
  logic        repack;
  logic [11:0] img_w;
  logic [15:0] img_h;
  logic [31:0] history [HIST_DEPTH];
  int unsigned in_col, in_row, out_col, out_row;

  out_pixel_t  pending_pixels[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  int          beats_sent = 0;

  function automatic logic [7:0] chan(logic [31:0] p, logic [4:0] s);
    return 8'((p >> s) & 32'hFF);
  endfunction

  function automatic int unsigned w_eff();
    if (img_w == 0) return 1;
    if (img_w > MAX_WIDTH) return MAX_WIDTH;
    return img_w;
  endfunction

  // Fill or repack the pixel at linear position lin.
  function automatic logic [31:0] fill_pixel(int unsigned lin, int unsigned w, int unsigned h);
    logic [31:0] c, p;
    int unsigned r, g, b, a, n, sr, sg, sb;
    int nx, ny;
    c = history[lin % HIST_DEPTH];
    if (!repack) return c;
    r = chan(c, sh_red); g = chan(c, sh_green); b = chan(c, sh_blue); a = chan(c, sh_alpha);
    if (a == 0 && fill_mode == TMODE_BLACK) begin
      r = 0; g = 0; b = 0;
    end else if (a == 0 && fill_mode == TMODE_AVG) begin
      n = 0; sr = 0; sg = 0; sb = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx = int'(out_col) + dx;
          ny = int'(out_row) + dy;
          if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < int'(w) && ny < int'(h)) begin
            p = history[(ny * w + nx) % HIST_DEPTH];
            if (chan(p, sh_alpha) != 0) begin
              n++; sr += chan(p, sh_red); sg += chan(p, sh_green); sb += chan(p, sh_blue);
            end
          end
        end
      end
      if (n != 0) begin
        r = sr / n; g = sg / n; b = sb / n;
      end else begin
        r = 0; g = 0; b = 0;
      end
    end
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  // Advance the shadow state by one accepted input beat.
  task automatic predict_pixel_beat(logic cmd, logic [31:0] px);
    int unsigned w, h, total, in_lin, out_lin;
    out_pixel_t o;
    w = w_eff();
    h = (img_h == 0) ? 1 : img_h;
    total = w * h;
    in_lin = in_row * w + in_col;
    out_lin = out_row * w + out_col;
    if (cmd == CMD_PIXEL && in_lin < total) begin
      history[in_lin % HIST_DEPTH] = px;
      in_lin++;
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
    end
    if (out_lin < in_lin && (in_lin >= total || in_lin >= out_lin + w + 2)) begin
      o.pixel = fill_pixel(out_lin, w, h);
      o.eor = (out_col + 1 == w);
      o.eof = (out_lin + 1 == total);
      pending_pixels.push_back(o);
      if (out_lin + 1 >= total) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0; out_row++;
        end
      end
    end
  endtask

  // Send one beat; called and returns at a falling edge, valid left high.
  task automatic send_beat(logic cmd, logic [31:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = px;
    do @(posedge clk); while (!in_tready);
    predict_pixel_beat(cmd, px);
    beats_sent++;
    @(negedge clk);
  endtask

  // Wait for every expected pixel, then let the core settle.
  task automatic drain();
    in_tvalid = 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RED_SHIFT:    sh_red = val[4:0];
      REG_GREEN_SHIFT:  sh_green = val[4:0];
      REG_BLUE_SHIFT:   sh_blue = val[4:0];
      REG_ALPHA_SHIFT:  sh_alpha = val[4:0];
      REG_TRANS_MODE:   fill_mode = val[1:0];
      REG_BITFIELDS:    repack = val[0];
      REG_IMAGE_WIDTH:  img_w = val[11:0];
      REG_IMAGE_HEIGHT: img_h = val[15:0];
      default: ;
    endcase
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(int rs, int gs, int bs, int as, int md, int bf, int w, int h);
    write_reg(REG_RED_SHIFT, 16'(rs));
    write_reg(REG_GREEN_SHIFT, 16'(gs));
    write_reg(REG_BLUE_SHIFT, 16'(bs));
    write_reg(REG_ALPHA_SHIFT, 16'(as));
    write_reg(REG_TRANS_MODE, 16'(md));
    write_reg(REG_BITFIELDS, 16'(bf));
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
  endtask

  // Random pixel; about half get a zero alpha byte so the fill path runs.
  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(1)) p &= ~(32'hFF << sh_alpha);
    return p;
  endfunction

  // One full frame plus its drain beats; some drain beats are pixels, which
  // the core drops. Optionally sprinkle early flushes into the frame.
  task automatic send_frame(bit noise);
    int unsigned w, h;
    w = w_eff();
    h = (img_h == 0) ? 1 : img_h;
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(9) == 0) send_beat(CMD_FLUSH, $urandom);
      send_beat(CMD_PIXEL, rand_pixel());
    end
    for (int i = 0; i <= w; i++) begin
      if ($urandom_range(3) == 0) send_beat(CMD_PIXEL, $urandom);
      else send_beat(CMD_FLUSH, $urandom);
    end
  endtask

  task automatic test_directed();
    // Shift extremes, neighbor average, all-zero and all-one pixels.
    setup(0, 31, 8, 24, TMODE_AVG, 1, 3, 3);
    send_beat(CMD_PIXEL, 32'h0000_0000);
    send_beat(CMD_FLUSH, 32'hFFFF_FFFF);       // early flush: no result
    send_beat(CMD_PIXEL, 32'hFFFF_FFFF);
    send_beat(CMD_PIXEL, 32'h00FF_00FF);
    send_beat(CMD_PIXEL, 32'h7F00_1234);
    send_beat(CMD_PIXEL, 32'h0000_00FF);
    send_beat(CMD_PIXEL, 32'h0180_8080);
    send_beat(CMD_PIXEL, 32'h00AB_CDEF);
    send_beat(CMD_PIXEL, 32'h8000_0001);
    send_beat(CMD_PIXEL, 32'h0000_0000);
    send_beat(CMD_PIXEL, 32'hDEAD_BEEF);       // dropped, acts as flush
    send_beat(CMD_FLUSH, 32'h0);
    send_beat(CMD_PIXEL, 32'h0);
    send_beat(CMD_FLUSH, 32'h0);
    drain();
    // Unused mode value, shifts above 24, zero width and height.
    setup(25, 31, 28, 26, 3, 1, 0, 0);
    send_beat(CMD_PIXEL, 32'hF0F0_0000);
    send_beat(CMD_FLUSH, 32'h0);
    send_beat(CMD_FLUSH, 32'h0);
    drain();
    // Raw pass-through.
    setup(16, 8, 0, 24, TMODE_BLACK, 0, 2, 1);
    send_beat(CMD_PIXEL, 32'h00FF_FFFF);
    send_beat(CMD_PIXEL, 32'h8000_0000);
    send_beat(CMD_FLUSH, 32'h0);
    send_beat(CMD_FLUSH, 32'h0);
    send_beat(CMD_FLUSH, 32'h0);
    drain();
  endtask

  task automatic test_random_frames(int sidle, int rstall, int beats);
    int start;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    start = beats_sent;
    while (beats_sent - start < beats) begin
      setup($urandom_range(31), $urandom_range(31), $urandom_range(31),
            ($urandom_range(3) == 0) ? $urandom_range(31) : 24,
            $urandom_range(3), ($urandom_range(7) != 0), $urandom_range(1, 8),
            $urandom_range(1, 5));
      send_frame(1'b1);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_holdoff();
    setup(16, 8, 0, 24, TMODE_AVG, 1, 4, 4);
    hold_left = 400;        // receiver blocks while the input keeps coming
    send_frame(1'b0);
    drain();
  endtask

  task automatic test_tall_frame_restart();
    // Start a very tall frame, stop partway; the next size write restarts.
    setup(16, 8, 0, 24, TMODE_AVG, 1, 2, 65535);
    for (int i = 0; i < 12; i++) send_beat(CMD_PIXEL, rand_pixel());
    drain();
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output beat against the oldest expected pixel.
  always @(posedge clk) begin
    out_pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: data %h eor %b eof %b",
                                   out_tdata, out_tuser, out_tlast);
      end else begin
        e = pending_pixels.pop_front();
        if (out_tdata !== e.pixel || out_tuser !== e.eor || out_tlast !== e.eof) begin
          errors++;
          if (errors <= 10)
            $display("beat mismatch: expected %h/%b/%b got %h/%b/%b",
                     e.pixel, e.eor, e.eof, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat anywhere.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("transparent_pixel_neighbor_fill_core: mismatch");
      $finish;
    end
  end

  initial begin
    sh_red = 16; sh_green = 8; sh_blue = 0; sh_alpha = 24;
    fill_mode = TMODE_KEEP; repack = 1; img_w = 2048; img_h = 1;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    foreach (history[i]) history[i] = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_frames(0, 0, 130);
    test_random_frames(57, 0, 125);
    test_random_frames(0, 57, 125);
    test_random_frames(37, 37, 125);
    test_tall_frame_restart();
    test_output_holdoff();
    drain();
    if (errors == 0)
      $display("transparent_pixel_neighbor_fill_core: match");
    else
      $display("transparent_pixel_neighbor_fill_core: mismatch");
    $finish;
  end

endmodule
